/* rtl/core/dte_pkg.sv */
// Types, codes and helpers shared by the decision tree evaluator.
// No dependencies; every other file in rtl/core except dte_ram imports this package.
package dte_pkg;

    // Command codes of an input item; any other code is dropped
    localparam logic [1:0] CMD_WRITE_NODE    = 2'd0;
    localparam logic [1:0] CMD_WRITE_FEATURE = 2'd1;
    localparam logic [1:0] CMD_EVALUATE      = 2'd2;

    // Depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_LESS      = 2'd0,
        OP_GREATER   = 2'd1,
        OP_EQUAL     = 2'd2,
        OP_NOT_EQUAL = 2'd3
    } t_operator;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_BAD_OP = 2'd2,
        STATUS_DEPTH  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_NODE    = 2'd0,
        JOB_FEATURE = 2'd1,
        JOB_EVAL    = 2'd2
    } t_job_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_NODE = 2'd1,
        BK_FEAT = 2'd2
    } t_back_state;

    // One tree node as held in the node memory (indices already reduced)
    typedef struct packed {
        logic               is_leaf;
        logic [5:0]         feature;
        logic               is_discrete;
        t_operator          op;
        logic signed [31:0] value;
        logic [7:0]         left;
        logic [7:0]         right;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    // One classified item travelling from front to back
    typedef struct packed {
        t_job_kind          kind;
        logic [7:0]         node_slot;
        t_node              node;
        logic [5:0]         feature_slot;
        logic signed [31:0] feat_value;
    } t_job;

    localparam int unsigned JOB_W = $bits(t_job);

    // One result item
    typedef struct packed {
        logic signed [31:0] prediction;
        logic               is_discrete;
        t_status            status;
    } t_result;

    // Reduce an 8-bit index modulo m by binary compare and subtract
    function automatic logic [7:0] reduce_index(logic [7:0] v, int unsigned m);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (32'(m) << k)) begin
                r = r - (32'(m) << k);
            end
        end
        return r[7:0];
    endfunction

endpackage

/* rtl/core/dte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dte_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/dte_front.sv */
// Front end: accepts items, reduces indices and packs them as jobs.
// Depends on dte_pkg.
module dte_front #(
    parameter int unsigned NODE_COUNT    = 256,
    parameter int unsigned FEATURE_COUNT = 64
) (
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_node_slot,
    input  logic               i_node_is_leaf,
    input  logic [5:0]         i_node_feature,
    input  logic               i_node_is_discrete,
    input  logic [1:0]         i_node_operator,
    input  logic signed [31:0] i_node_value,
    input  logic [7:0]         i_left_child,
    input  logic [7:0]         i_right_child,
    input  logic [5:0]         i_feature_slot,
    input  logic signed [31:0] i_feat_value,
    input  logic               i_queue_full,
    output logic               o_push,
    output dte_pkg::t_job      o_job
);
    import dte_pkg::*;

    logic accept;
    logic [7:0] feat_red;
    logic [7:0] slot_red;

    assign busy   = i_queue_full;
    assign accept = start && !busy;

    // Reduce feature indices to the feature store size
    assign feat_red = reduce_index({2'b00, i_node_feature}, FEATURE_COUNT);
    assign slot_red = reduce_index({2'b00, i_feature_slot}, FEATURE_COUNT);

    // Classify the item and build the job
    always_comb begin
        o_push             = 1'b0;
        o_job.kind         = JOB_EVAL;
        o_job.node_slot    = reduce_index(i_node_slot, NODE_COUNT);
        o_job.node.is_leaf = i_node_is_leaf;
        o_job.node.feature = feat_red[5:0];
        o_job.node.is_discrete = i_node_is_discrete;
        o_job.node.op      = t_operator'(i_node_operator);
        o_job.node.value   = i_node_value;
        o_job.node.left    = reduce_index(i_left_child, NODE_COUNT);
        o_job.node.right   = reduce_index(i_right_child, NODE_COUNT);
        o_job.feature_slot = slot_red[5:0];
        o_job.feat_value   = i_feat_value;
        priority if (i_command == CMD_WRITE_NODE) begin
            o_job.kind = JOB_NODE;
            o_push     = accept;
        end else if (i_command == CMD_WRITE_FEATURE) begin
            o_job.kind = JOB_FEATURE;
            o_push     = accept;
        end else if (i_command == CMD_EVALUATE) begin
            o_job.kind = JOB_EVAL;
            o_push     = accept;
        end else begin
            // drop unknown commands
            o_push = 1'b0;
        end
    end
endmodule

/* rtl/core/dte_queue.sv */
// Short register queue between front and back end.
// Depends on dte_pkg.
module dte_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import dte_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

/* rtl/core/dte_back.sv */
// Back end: carries out node and feature writes and walks the tree.
// Depends on dte_pkg and dte_ram.
module dte_back #(
    parameter int unsigned NODE_COUNT    = 256,
    parameter int unsigned FEATURE_COUNT = 64,
    parameter int unsigned MAX_DEPTH     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  dte_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_res_valid,
    output dte_pkg::t_result o_res
);
    import dte_pkg::*;

    localparam int unsigned NA = $clog2(NODE_COUNT);
    localparam int unsigned FA = $clog2(FEATURE_COUNT);
    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

    t_back_state r_state, n_state;
    logic [DW-1:0] r_depth, n_depth;
    logic r_loaded, n_loaded;
    logic r_res_valid;
    t_result r_res;

    logic res_valid;
    t_result res;

    logic node_wr_en, node_rd_en;
    logic [NA-1:0] node_rd_addr;
    logic [NODE_W-1:0] node_q_raw;
    t_node node_q;
    logic feat_wr_en, feat_rd_en;
    logic [31:0] feat_q;
    logic op_fits;
    logic pass;
    logic [7:0] next_idx;

    dte_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (node_wr_en),
        .i_wr_addr (NA'(i_job.node_slot)),
        .i_wr_data (i_job.node),
        .i_rd_en   (node_rd_en),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (node_q_raw)
    );

    dte_ram #(.WIDTH(32), .DEPTH(FEATURE_COUNT)) u_feat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (feat_wr_en),
        .i_wr_addr (FA'(i_job.feature_slot)),
        .i_wr_data (i_job.feat_value),
        .i_rd_en   (feat_rd_en),
        .i_rd_addr (FA'(node_q.feature)),
        .o_rd_data (feat_q)
    );

    assign node_q = t_node'(node_q_raw);

    // Operator must suit the feature type
    assign op_fits = node_q.is_discrete ?
                     (node_q.op == OP_EQUAL || node_q.op == OP_NOT_EQUAL) :
                     (node_q.op == OP_LESS || node_q.op == OP_GREATER);

    // Left test of the current split node
    always_comb begin
        unique case (node_q.op)
            OP_LESS:      pass = $signed(feat_q) < $signed(node_q.value);
            OP_GREATER:   pass = $signed(feat_q) > $signed(node_q.value);
            OP_EQUAL:     pass = (feat_q == node_q.value);
            OP_NOT_EQUAL: pass = (feat_q != node_q.value);
            default:      pass = 1'b0;
        endcase
    end

    assign next_idx = pass ? node_q.left : node_q.right;

    // Next state, memory control and result
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_loaded     = r_loaded;
        o_pop        = 1'b0;
        node_wr_en   = 1'b0;
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        feat_wr_en   = 1'b0;
        feat_rd_en   = 1'b0;
        res_valid    = 1'b0;
        res.prediction  = '0;
        res.is_discrete = 1'b0;
        res.status      = STATUS_OK;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        JOB_NODE: begin
                            node_wr_en = 1'b1;
                            if (i_job.node_slot == '0) begin
                                n_loaded = 1'b1;
                            end
                        end
                        JOB_FEATURE: begin
                            feat_wr_en = 1'b1;
                        end
                        JOB_EVAL: begin
                            if (!r_loaded) begin
                                res_valid  = 1'b1;
                                res.status = STATUS_EMPTY;
                            end else begin
                                node_rd_en = 1'b1;
                                n_depth    = '0;
                                n_state    = BK_NODE;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_NODE: begin
                priority if (node_q.is_leaf) begin
                    res_valid       = 1'b1;
                    res.prediction  = node_q.value;
                    res.is_discrete = node_q.is_discrete;
                    n_state         = BK_IDLE;
                end else if (r_depth == DW'(MAX_DEPTH)) begin
                    res_valid  = 1'b1;
                    res.status = STATUS_DEPTH;
                    n_state    = BK_IDLE;
                end else if (!op_fits) begin
                    res_valid  = 1'b1;
                    res.status = STATUS_BAD_OP;
                    n_state    = BK_IDLE;
                end else begin
                    feat_rd_en = 1'b1;
                    n_state    = BK_FEAT;
                end
            end
            BK_FEAT: begin
                node_rd_en   = 1'b1;
                node_rd_addr = NA'(next_idx);
                n_depth      = r_depth + 1'b1;
                n_state      = BK_NODE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_depth     <= '0;
            r_loaded    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_loaded    <= n_loaded;
            r_res_valid <= res_valid;
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule

/* rtl/core/decision_tree_evaluator_core.sv */
// Top level of the decision tree evaluator: front end, queue, back end.
// Depends on dte_pkg, dte_front, dte_queue, dte_back and dte_ram.
//
//  Channel   Handshake            Payload
//  items in  start / busy         i_command, i_node_*, i_left_child, i_right_child,
//                                 i_feature_slot, i_feat_value
//  results   o_done (one cycle)   o_prediction, o_prediction_is_discrete, o_status
//
// An item is taken when start is high and busy is low; busy rises only while
// the two-entry queue is full. A write item is carried out as it leaves the
// queue. An evaluate item starts a node memory read of the root as it leaves the
// queue, then passes S split nodes (at most MAX_DEPTH): each level alternates
// one node memory read and one feature memory read; the result strobe is
// registered. With no tree loaded the result is given without a walk.
// Reset clears control state and the tree-loaded flag; the
// memories are not cleared. Results cannot be held off by the receiver.
module decision_tree_evaluator_core #(
    parameter int unsigned NODE_COUNT    = 256,
    parameter int unsigned FEATURE_COUNT = 64,
    parameter int unsigned MAX_DEPTH     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_node_slot,
    input  logic               i_node_is_leaf,
    input  logic [5:0]         i_node_feature,
    input  logic               i_node_is_discrete,
    input  logic [1:0]         i_node_operator,
    input  logic signed [31:0] i_node_value,
    input  logic [7:0]         i_left_child,
    input  logic [7:0]         i_right_child,
    input  logic [5:0]         i_feature_slot,
    input  logic signed [31:0] i_feat_value,
    output logic               o_done,
    output logic signed [31:0] o_prediction,
    output logic               o_prediction_is_discrete,
    output logic [1:0]         o_status
);
    import dte_pkg::*;

    logic push, pop, q_full, q_empty;
    t_job job_in;
    logic [JOB_W-1:0] job_out;
    t_result res;

    dte_front #(.NODE_COUNT(NODE_COUNT), .FEATURE_COUNT(FEATURE_COUNT)) u_front (
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_node_slot        (i_node_slot),
        .i_node_is_leaf     (i_node_is_leaf),
        .i_node_feature     (i_node_feature),
        .i_node_is_discrete (i_node_is_discrete),
        .i_node_operator    (i_node_operator),
        .i_node_value       (i_node_value),
        .i_left_child       (i_left_child),
        .i_right_child      (i_right_child),
        .i_feature_slot     (i_feature_slot),
        .i_feat_value       (i_feat_value),
        .i_queue_full       (q_full),
        .o_push             (push),
        .o_job              (job_in)
    );

    dte_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dte_back #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (t_job'(job_out)),
        .o_pop       (pop),
        .o_res_valid (o_done),
        .o_res       (res)
    );

    assign o_prediction             = res.prediction;
    assign o_prediction_is_discrete = res.is_discrete;
    assign o_status                 = res.status;

    // Queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("job pushed into full queue");

    // Queue is never read while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_empty))
        else $error("job popped from empty queue");

    // A failed walk reports a zero prediction
    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STATUS_OK) |->
        (o_prediction == '0 && !o_prediction_is_discrete))
        else $error("error result carries a prediction");

    // No result in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for decision_tree_evaluator_core: node, feature and evaluate items
// are driven through start/busy, and every evaluation is checked against an in-bench tree walk.
// Depends on dte_pkg and the decision tree evaluator RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dte_pkg::*;

    localparam int unsigned NODE_COUNT    = 256;
    localparam int unsigned FEATURE_COUNT = 64;
    localparam int unsigned MAX_DEPTH     = 16;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          TAIL_CYCLES   = 150;
    localparam int          PHASE_ITEMS   = 375;

    // One input item as queued for the driver
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  node_slot;
        logic        is_leaf;
        logic [5:0]  node_feature;
        logic        is_discrete;
        logic [1:0]  op;
        logic [31:0] node_value;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [5:0]  feature_slot;
        logic [31:0] feat_value;
    } t_cmd_item;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [7:0]         i_node_slot;
    logic               i_node_is_leaf;
    logic [5:0]         i_node_feature;
    logic               i_node_is_discrete;
    logic [1:0]         i_node_operator;
    logic signed [31:0] i_node_value;
    logic [7:0]         i_left_child;
    logic [7:0]         i_right_child;
    logic [5:0]         i_feature_slot;
    logic signed [31:0] i_feat_value;
    logic               o_done;
    logic signed [31:0] o_prediction;
    logic               o_prediction_is_discrete;
    logic [1:0]         o_status;

    // Stimulus side: items waiting for the driver and what has been written so far
    t_cmd_item   pending_items[$];
    bit          node_written[NODE_COUNT];
    bit          feat_written[FEATURE_COUNT];
    logic [7:0]  node_list[$];
    logic [5:0]  feat_list[$];
    int          idle_pct;
    int          items_issued;

    // Prediction side: shadow of the tree and the instance, and results still owed
    t_node       shadow_nodes[NODE_COUNT];
    logic [31:0] shadow_features[FEATURE_COUNT];
    bit          shadow_loaded;
    t_result     pending_predictions[$];

    logic        item_taken;
    int          mismatch_count;
    int          results_checked;
    int          status_seen[4];
    int          quiet_cycles;

    decision_tree_evaluator_core #(
        .NODE_COUNT   (NODE_COUNT),
        .FEATURE_COUNT(FEATURE_COUNT),
        .MAX_DEPTH    (MAX_DEPTH)
    ) i_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_command               (i_command),
        .i_node_slot             (i_node_slot),
        .i_node_is_leaf          (i_node_is_leaf),
        .i_node_feature          (i_node_feature),
        .i_node_is_discrete      (i_node_is_discrete),
        .i_node_operator         (i_node_operator),
        .i_node_value            (i_node_value),
        .i_left_child            (i_left_child),
        .i_right_child           (i_right_child),
        .i_feature_slot          (i_feature_slot),
        .i_feat_value            (i_feat_value),
        .o_done                  (o_done),
        .o_prediction            (o_prediction),
        .o_prediction_is_discrete(o_prediction_is_discrete),
        .o_status                (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Walk the shadow tree from the root and return the result the block owes
    function automatic t_result tree_walk();
        t_result            res;
        t_node              nd;
        logic [7:0]         idx;
        logic signed [31:0] fv;
        bit                 pass;
        res = '0;
        if (!shadow_loaded) begin
            res.status = STATUS_EMPTY;
            return res;
        end
        idx = 8'd0;
        res.status = STATUS_DEPTH;
        for (int lvl = 0; lvl <= MAX_DEPTH; lvl++) begin
            nd = shadow_nodes[idx];
            if (nd.is_leaf) begin
                res.prediction  = nd.value;
                res.is_discrete = nd.is_discrete;
                res.status      = STATUS_OK;
                return res;
            end
            if (lvl == MAX_DEPTH) begin
                return res;
            end
            fv = shadow_features[nd.feature];
            if (nd.is_discrete && nd.op == OP_EQUAL) begin
                pass = (fv == nd.value);
            end else if (nd.is_discrete && nd.op == OP_NOT_EQUAL) begin
                pass = (fv != nd.value);
            end else if (!nd.is_discrete && nd.op == OP_LESS) begin
                pass = (fv < nd.value);
            end else if (!nd.is_discrete && nd.op == OP_GREATER) begin
                pass = (fv > nd.value);
            end else begin
                res.status = STATUS_BAD_OP;
                return res;
            end
            idx = pass ? nd.left : nd.right;
        end
        return res;
    endfunction

    // Mostly small values and extremes so that equality and sign edges come up often
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(7));
            4:          return 32'h8000_0000;
            5:          return 32'h7fff_ffff;
            6:          return 32'hffff_ffff;
            default:    return $urandom();
        endcase
    endfunction

    function automatic t_cmd_item random_item();
        t_cmd_item it;
        it.cmd           = CMD_UNUSED;
        it.node_slot     = 8'($urandom_range(255));
        it.is_leaf       = 1'($urandom_range(1));
        it.node_feature  = 6'($urandom_range(63));
        it.is_discrete   = 1'($urandom_range(1));
        it.op            = 2'($urandom_range(3));
        it.node_value    = $urandom();
        it.left          = 8'($urandom_range(255));
        it.right         = 8'($urandom_range(255));
        it.feature_slot  = 6'($urandom_range(63));
        it.feat_value    = $urandom();
        return it;
    endfunction

    function automatic logic [7:0] pick_node();
        return node_list[$urandom_range(node_list.size() - 1)];
    endfunction

    function automatic logic [5:0] pick_feature();
        return feat_list[$urandom_range(feat_list.size() - 1)];
    endfunction

    task automatic queue_node(input logic [7:0] slot, input bit leaf, input logic [5:0] feat,
                              input bit disc, input logic [1:0] op, input logic [31:0] value,
                              input logic [7:0] lft, input logic [7:0] rgt);
        t_cmd_item it;
        it              = random_item();
        it.cmd          = CMD_WRITE_NODE;
        it.node_slot    = slot;
        it.is_leaf      = leaf;
        it.node_feature = feat;
        it.is_discrete  = disc;
        it.op           = op;
        it.node_value   = value;
        it.left         = lft;
        it.right        = rgt;
        pending_items.insert(pending_items.size(), it);
        items_issued++;
        if (!node_written[slot]) begin
            node_written[slot] = 1'b1;
            node_list.insert(node_list.size(), slot);
        end
    endtask

    task automatic queue_feature(input logic [5:0] slot, input logic [31:0] value);
        t_cmd_item it;
        it               = random_item();
        it.cmd           = CMD_WRITE_FEATURE;
        it.feature_slot  = slot;
        it.feat_value    = value;
        pending_items.insert(pending_items.size(), it);
        items_issued++;
        if (!feat_written[slot]) begin
            feat_written[slot] = 1'b1;
            feat_list.insert(feat_list.size(), slot);
        end
    endtask

    task automatic queue_eval();
        t_cmd_item it;
        it     = random_item();
        it.cmd = CMD_EVALUATE;
        pending_items.insert(pending_items.size(), it);
        items_issued++;
    endtask

    // Split on a written feature; children must already be written so no walk hits a hole
    task automatic queue_split(input logic [7:0] slot, input logic [7:0] lft,
                               input logic [7:0] rgt, input bit allow_bad);
        bit         disc;
        logic [1:0] op;
        disc = 1'($urandom_range(1));
        if (disc) begin
            op = $urandom_range(1) ? OP_EQUAL : OP_NOT_EQUAL;
        end else begin
            op = $urandom_range(1) ? OP_LESS : OP_GREATER;
        end
        // Swap to the operator family of the other type now and then
        if (allow_bad && $urandom_range(9) == 0) begin
            op = op ^ 2'b10;
        end
        queue_node(slot, 1'b0, pick_feature(), disc, op, rand_word(), lft, rgt);
    endtask

    task automatic queue_random_node();
        logic [7:0] slot;
        slot = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
        if ($urandom_range(99) < 35) begin
            queue_node(slot, 1'b1, 6'($urandom_range(63)), 1'($urandom_range(1)),
                       2'($urandom_range(3)), rand_word(), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        end else begin
            queue_split(slot, pick_node(), pick_node(), 1'b1);
        end
    endtask

    // Build a straight chain of splits from the root around the depth limit, then evaluate
    task automatic queue_chain();
        int         len;
        logic [7:0] nxt;
        logic [7:0] slot;
        len = $urandom_range(MAX_DEPTH + 1, MAX_DEPTH - 2);
        nxt = 8'($urandom_range(255, 1));
        if ($urandom_range(3) != 0) begin
            queue_node(nxt, 1'b1, 6'($urandom_range(63)), 1'($urandom_range(1)),
                       2'($urandom_range(3)), rand_word(), 8'd0, 8'd0);
        end else begin
            queue_split(nxt, pick_node(), pick_node(), 1'b0);
        end
        for (int k = 1; k < len; k++) begin
            slot = 8'($urandom_range(255, 1));
            queue_split(slot, nxt, nxt, 1'b0);
            nxt = slot;
        end
        queue_split(8'd0, nxt, nxt, 1'b0);
        queue_eval();
    endtask

    task automatic queue_random_phase(input int count);
        int target;
        target = items_issued + count;
        while (items_issued < target) begin
            case ($urandom_range(99)) inside
                [0:35]:  queue_eval();
                [36:59]: queue_random_node();
                [60:87]: queue_feature(6'($urandom_range(63)), rand_word());
                [88:91]: queue_chain();
                default: pending_items.insert(pending_items.size(), random_item());
            endcase
        end
    endtask

    // Driver: present the next item at the falling edge, hold it while busy
    always @(negedge i_clk) begin : drive_items
        t_cmd_item it;
        if (i_rst_n && (!start || item_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                it                  = pending_items.pop_front();
                i_command          <= it.cmd;
                i_node_slot        <= it.node_slot;
                i_node_is_leaf     <= it.is_leaf;
                i_node_feature     <= it.node_feature;
                i_node_is_discrete <= it.is_discrete;
                i_node_operator    <= it.op;
                i_node_value       <= it.node_value;
                i_left_child       <= it.left;
                i_right_child      <= it.right;
                i_feature_slot     <= it.feature_slot;
                i_feat_value       <= it.feat_value;
                start              <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results, update the shadow on each accepted item, watch for a hang
    always @(posedge i_clk) begin : check_results
        t_result want;
        t_node   nd;
        item_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            // Compare the result against the oldest prediction
            if (o_done) begin
                if (pending_predictions.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected: prediction %h status %0d",
                             $time, o_prediction, o_status);
                end else begin
                    want = pending_predictions.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (o_prediction !== want.prediction) begin
                        mismatch_count++;
                        $display("%0t: prediction expected %h got %h",
                                 $time, want.prediction, o_prediction);
                    end
                    if (o_prediction_is_discrete !== want.is_discrete) begin
                        mismatch_count++;
                        $display("%0t: discrete flag expected %b got %b",
                                 $time, want.is_discrete, o_prediction_is_discrete);
                    end
                    if (o_status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_status);
                    end
                end
            end
            // Apply the accepted item to the shadow state
            if (start && !busy) begin
                case (i_command)
                    CMD_WRITE_NODE: begin
                        nd.is_leaf     = i_node_is_leaf;
                        nd.feature     = i_node_feature;
                        nd.is_discrete = i_node_is_discrete;
                        nd.op          = t_operator'(i_node_operator);
                        nd.value       = i_node_value;
                        nd.left        = i_left_child;
                        nd.right       = i_right_child;
                        shadow_nodes[i_node_slot] = nd;
                        if (i_node_slot == 8'd0) begin
                            shadow_loaded = 1'b1;
                        end
                    end
                    CMD_WRITE_FEATURE: begin
                        shadow_features[i_feature_slot] = i_feat_value;
                    end
                    CMD_EVALUATE: begin
                        pending_predictions.insert(pending_predictions.size(), tree_walk());
                    end
                    default: begin
                    end
                endcase
            end
            if ((start && !busy) || o_done) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("decision_tree_evaluator_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_command          = CMD_UNUSED;
        i_node_slot        = '0;
        i_node_is_leaf     = 1'b0;
        i_node_feature     = '0;
        i_node_is_discrete = 1'b0;
        i_node_operator    = OP_LESS;
        i_node_value       = '0;
        i_left_child       = '0;
        i_right_child      = '0;
        i_feature_slot     = '0;
        i_feat_value       = '0;
        item_taken         = 1'b0;
        shadow_loaded      = 1'b0;
        idle_pct           = 0;
        items_issued       = 0;
        mismatch_count     = 0;
        results_checked    = 0;
        quiet_cycles       = 0;
        for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
        end

        // Directed: empty tree, both leaf kinds, every operator, signed edges, bad pairs, loop
        queue_eval();
        queue_feature(6'd0, 32'h8000_0000);
        queue_feature(6'd63, 32'h7fff_ffff);
        queue_feature(6'd1, 32'd5);
        queue_node(8'd1, 1'b1, 6'd0, 1'b0, OP_LESS, 32'h8000_0000, 8'd0, 8'd0);
        queue_node(8'd255, 1'b1, 6'd0, 1'b1, OP_LESS, 32'h7fff_ffff, 8'd0, 8'd0);
        queue_node(8'd0, 1'b0, 6'd0, 1'b0, OP_LESS, 32'h8000_0000, 8'd1, 8'd255);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd63, 1'b0, OP_GREATER, 32'h7fff_fffe, 8'd1, 8'd255);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd1, 1'b1, OP_EQUAL, 32'd5, 8'd255, 8'd1);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd1, 1'b1, OP_NOT_EQUAL, 32'd5, 8'd255, 8'd1);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd1, 1'b1, OP_GREATER, 32'd5, 8'd255, 8'd1);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd63, 1'b0, OP_NOT_EQUAL, 32'd5, 8'd255, 8'd1);
        queue_eval();
        queue_node(8'd0, 1'b0, 6'd0, 1'b0, OP_LESS, 32'd0, 8'd0, 8'd0);
        queue_eval();
        pending_items.insert(pending_items.size(), random_item());

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Random phases: no gaps, heavy sender gaps, light gaps, no gaps again
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 77;
                2:       idle_pct = 30;
                default: idle_pct = 0;
            endcase
            queue_random_phase(PHASE_ITEMS);
            while (pending_items.size() > 0) @(posedge i_clk);
        end

        // Drain: let every item in and every result out, then allow for stragglers
        while (pending_items.size() > 0 || start) @(posedge i_clk);
        while (pending_predictions.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d items issued; %0d evaluations checked: %0d ok, %0d empty tree,",
                 items_issued, results_checked, status_seen[STATUS_OK],
                 status_seen[STATUS_EMPTY]);
        $display("%0d bad operator, %0d depth limit; %0d mismatches, %0d results missing",
                 status_seen[STATUS_BAD_OP], status_seen[STATUS_DEPTH], mismatch_count,
                 pending_predictions.size());
        if (mismatch_count == 0 && pending_predictions.size() == 0) begin
            $display("decision_tree_evaluator_core: match");
        end else begin
            $display("decision_tree_evaluator_core: mismatch");
        end
        $finish;
    end

endmodule
